>>> sv/lga_pkg.sv
`default_nettype none

package lga_pkg;

  localparam int KIND_W = 2;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 5;

  localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd2;

  // Port enables of the grid memory
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

`default_nettype wire

>>> sv/lga_grid_mem.sv
`default_nettype none

module lga_grid_mem
  import lga_pkg::*;
#(
  parameter int Depth = 32,
  parameter int Width = 32,
  parameter int AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire mem_ctl_t         ctl_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [Width-1:0] wr_data_i,
  output logic      [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem [Depth];
  logic [Depth-1:0] valid_q;
  logic [Width-1:0] rd_data_q;

  // Rows never written since reset read as dead
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctl_i.wr_en) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_data_q <= valid_q[rd_addr_i] ? mem[rd_addr_i] : '0;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> sv/lga_rule.sv
`default_nettype none

module lga_rule
  import lga_pkg::*;
#(
  parameter int Width = 32
) (
  input  wire logic [Width-1:0] above_i,
  input  wire logic [Width-1:0] here_i,
  input  wire logic [Width-1:0] below_i,
  output logic      [Width-1:0] fresh_o
);

  logic [Width+1:0] above_x;
  logic [Width+1:0] here_x;
  logic [Width+1:0] below_x;

  // Pad one dead cell on each side
  assign above_x = {1'b0, above_i, 1'b0};
  assign here_x  = {1'b0, here_i, 1'b0};
  assign below_x = {1'b0, below_i, 1'b0};

  always_comb begin
    logic [3:0] around;
    around = '0;
    fresh_o = '0;
    for (int c = 0; c < Width; c++) begin
      around = 4'(above_x[c]) + 4'(above_x[c+1]) + 4'(above_x[c+2])
             + 4'(here_x[c]) + 4'(here_x[c+2])
             + 4'(below_x[c]) + 4'(below_x[c+1]) + 4'(below_x[c+2]);
      fresh_o[c] = (around == 4'd3) || (here_i[c] && (around == 4'd2));
    end
  end

endmodule

`default_nettype wire

>>> sv/life_automaton_grid_step.sv
`default_nettype none

// Game of Life grid (rule B3/S23), one row of GRID_WIDTH cells per memory word.
// Command channel: start_i with kind_i, row_i, col_i, cell_in_i is taken at a
// clock edge where start_i is high and busy_o is low. kind_i selects write cell,
// read cell or advance one generation; unused kinds do nothing.
// Every command yields one result: done_o pulses for one cycle with cell_out_o,
// which carries the cell for a read and 0 otherwise.
// Write and read go through a memory read, then a modify/write back, and done_o
// is registered from that last step. An advance prefetches the first rows, then
// handles one row per cycle through the single read and single write port of
// the grid memory, with the two older rows held in registers.
// busy_o drops as the last cycle ends, so a new command may be taken in the
// cycle where done_o is shown. The receiver cannot stall; results are never held.
// Reset clears the valid bit of every row at once, so the grid reads as all
// dead right after reset without a clearing pass.
// Addresses outside the grid: writes are dropped, reads return 0.

module life_automaton_grid_step
  import lga_pkg::*;
#(
  parameter int GRID_HEIGHT = 32,
  parameter int GRID_WIDTH  = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [KIND_W-1:0] kind_i,
  input  wire logic [ROW_W-1:0]  row_i,
  input  wire logic [COL_W-1:0]  col_i,
  input  wire logic              cell_in_i,
  output logic                   done_o,
  output logic                   cell_out_o
);

  localparam int RW = $clog2(GRID_HEIGHT);
  localparam int CW = $clog2(GRID_WIDTH);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FIN   = 3'd1;
  localparam logic [2:0] ST_LOAD1 = 3'd2;
  localparam logic [2:0] ST_RUN   = 3'd3;

  logic [2:0]            state_q, state_d;
  logic [RW-1:0]         cnt_q, cnt_d;
  logic [KIND_W-1:0]     kind_q;
  logic [ROW_W-1:0]      row_q;
  logic [COL_W-1:0]      col_q;
  logic                  cell_q;
  logic [GRID_WIDTH-1:0] prev_q, prev_d;
  logic [GRID_WIDTH-1:0] cur_q, cur_d;
  logic                  done_q, done_d;
  logic                  out_q, out_d;

  mem_ctl_t              mem_ctl;
  logic [RW-1:0]         rd_addr;
  logic [RW-1:0]         wr_addr;
  logic [GRID_WIDTH-1:0] wr_data;
  logic [GRID_WIDTH-1:0] rd_data;
  logic [GRID_WIDTH-1:0] below;
  logic [GRID_WIDTH-1:0] fresh;

  logic                  accept;
  logic                  in_grid;
  logic [CW-1:0]         col_idx;
  logic                  last_row;

  assign accept   = start_i && (state_q == ST_IDLE);
  assign in_grid  = (32'(row_q) < GRID_HEIGHT) && (32'(col_q) < GRID_WIDTH);
  assign col_idx  = CW'(col_q);
  assign last_row = (cnt_q == RW'(GRID_HEIGHT - 1));
  assign below    = last_row ? '0 : rd_data;

  lga_grid_mem #(
    .Depth (GRID_HEIGHT),
    .Width (GRID_WIDTH),
    .AddrW (RW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mem_ctl),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  lga_rule #(
    .Width (GRID_WIDTH)
  ) u_rule (
    .above_i (prev_q),
    .here_i  (cur_q),
    .below_i (below),
    .fresh_o (fresh)
  );

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    prev_d        = prev_q;
    cur_d         = cur_q;
    done_d        = 1'b0;
    out_d         = 1'b0;
    mem_ctl.rd_en = 1'b0;
    mem_ctl.wr_en = 1'b0;
    rd_addr       = '0;
    wr_addr       = RW'(row_q);
    wr_data       = rd_data;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          mem_ctl.rd_en = 1'b1;
          if (kind_i == KIND_ADVANCE) begin
            rd_addr = '0;
            state_d = ST_LOAD1;
          end else begin
            rd_addr = RW'(row_i);
            state_d = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        wr_data[col_idx] = cell_q;
        mem_ctl.wr_en    = (kind_q == KIND_WRITE) && in_grid;
        out_d            = (kind_q == KIND_READ) && in_grid && rd_data[col_idx];
        done_d           = 1'b1;
        state_d          = ST_IDLE;
      end
      ST_LOAD1: begin
        // Row 0 arrives; fetch row 1
        prev_d        = '0;
        cur_d         = rd_data;
        cnt_d         = '0;
        mem_ctl.rd_en = 1'b1;
        rd_addr       = RW'(1);
        state_d       = ST_RUN;
      end
      ST_RUN: begin
        // Write back row cnt, shift the window down, fetch two rows ahead
        wr_addr       = cnt_q;
        wr_data       = fresh;
        mem_ctl.wr_en = 1'b1;
        prev_d        = cur_q;
        cur_d         = below;
        if (32'(cnt_q) + 2 < GRID_HEIGHT) begin
          mem_ctl.rd_en = 1'b1;
          rd_addr       = cnt_q + RW'(2);
        end
        if (last_row) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + RW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      out_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      out_q   <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      row_q  <= row_i;
      col_q  <= col_i;
      cell_q <= cell_in_i;
    end
    prev_q <= prev_d;
    cur_q  <= cur_d;
  end

  assign busy_o     = (state_q != ST_IDLE);
  assign done_o     = done_q;
  assign cell_out_o = out_q;

endmodule

`default_nettype wire

>>> verif/life_automaton_grid_step_tb.sv
`default_nettype none

module life_automaton_grid_step_tb;
  import lga_pkg::*;

  localparam int GRID_H = 32;
  localparam int GRID_W = 32;
  localparam int NUM_DIRECTED = 26;
  localparam int NUM_ITEMS = 500;
  localparam int STALL_LIMIT = 2000;
  localparam int CALM_FROM = 430;

  // Kind code that the block must treat as a no-op
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              cell_val;
    logic              known;
    logic              known_val;
  } cmd_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [KIND_W-1:0] kind_i;
  logic [ROW_W-1:0]  row_i;
  logic [COL_W-1:0]  col_i;
  logic              cell_in_i;
  logic              done_o;
  logic              cell_out_o;

  logic [GRID_W-1:0] grid_model [GRID_H];
  logic              cell_q [$];
  logic              want_cell;
  int                mismatch_count = 0;
  int                items_sent = 0;
  int                stall_cycles;
  bit                idle_on = 1'b1;

  cmd_row_t dir_tbl [NUM_DIRECTED] = '{
    '{KIND_READ,    5'd0,  5'd0,  1'b0, 1'b1, 1'b0},
    '{KIND_READ,    5'd31, 5'd31, 1'b0, 1'b1, 1'b0},
    '{KIND_WRITE,   5'd0,  5'd0,  1'b1, 1'b1, 1'b0},
    '{KIND_WRITE,   5'd0,  5'd31, 1'b1, 1'b1, 1'b0},
    '{KIND_WRITE,   5'd31, 5'd0,  1'b1, 1'b1, 1'b0},
    '{KIND_WRITE,   5'd31, 5'd31, 1'b1, 1'b1, 1'b0},
    '{KIND_READ,    5'd0,  5'd31, 1'b0, 1'b1, 1'b1},
    '{KIND_READ,    5'd31, 5'd0,  1'b0, 1'b1, 1'b1},
    '{KIND_SPARE,   5'd31, 5'd31, 1'b1, 1'b1, 1'b0},
    '{KIND_READ,    5'd31, 5'd31, 1'b0, 1'b1, 1'b1},
    '{KIND_WRITE,   5'd31, 5'd31, 1'b0, 1'b1, 1'b0},
    '{KIND_READ,    5'd31, 5'd31, 1'b0, 1'b1, 1'b0},
    // lone corner cells die
    '{KIND_ADVANCE, 5'd7,  5'd19, 1'b1, 1'b1, 1'b0},
    '{KIND_READ,    5'd0,  5'd0,  1'b0, 1'b1, 1'b0},
    // blinker on the top border
    '{KIND_WRITE,   5'd0,  5'd14, 1'b1, 1'b1, 1'b0},
    '{KIND_WRITE,   5'd0,  5'd15, 1'b1, 1'b1, 1'b0},
    '{KIND_WRITE,   5'd0,  5'd16, 1'b1, 1'b1, 1'b0},
    '{KIND_ADVANCE, 5'd0,  5'd0,  1'b0, 1'b1, 1'b0},
    '{KIND_READ,    5'd1,  5'd15, 1'b0, 1'b0, 1'b0},
    '{KIND_READ,    5'd0,  5'd15, 1'b0, 1'b0, 1'b0},
    '{KIND_READ,    5'd0,  5'd14, 1'b0, 1'b0, 1'b0},
    // L shape in the bottom-right corner fills to a block
    '{KIND_WRITE,   5'd31, 5'd30, 1'b1, 1'b1, 1'b0},
    '{KIND_WRITE,   5'd31, 5'd31, 1'b1, 1'b1, 1'b0},
    '{KIND_WRITE,   5'd30, 5'd31, 1'b1, 1'b1, 1'b0},
    '{KIND_ADVANCE, 5'd31, 5'd31, 1'b1, 1'b1, 1'b0},
    '{KIND_READ,    5'd30, 5'd30, 1'b0, 1'b0, 1'b0}
  };

  life_automaton_grid_step #(
    .GRID_HEIGHT(GRID_H),
    .GRID_WIDTH (GRID_W)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .busy_o    (busy_o),
    .kind_i    (kind_i),
    .row_i     (row_i),
    .col_i     (col_i),
    .cell_in_i (cell_in_i),
    .done_o    (done_o),
    .cell_out_o(cell_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void next_generation();
    logic [GRID_W-1:0] prior [GRID_H];
    int nbrs;
    int rr;
    int cc;
    prior = grid_model;
    for (int r = 0; r < GRID_H; r++) begin
      for (int c = 0; c < GRID_W; c++) begin
        nbrs = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            rr = r + dr;
            cc = c + dc;
            // cells past the border count as dead, no wrap
            if ((dr != 0 || dc != 0) && rr >= 0 && rr < GRID_H && cc >= 0 && cc < GRID_W)
              nbrs += prior[rr][cc];
          end
        end
        grid_model[r][c] = prior[r][c] ? (nbrs == 2 || nbrs == 3) : (nbrs == 3);
      end
    end
  endfunction

  function automatic logic apply_command(input logic [KIND_W-1:0] k, input logic [ROW_W-1:0] r,
                                         input logic [COL_W-1:0] c, input logic v);
    logic res;
    res = 1'b0;
    case (k)
      KIND_WRITE: begin
        if (r < GRID_H && c < GRID_W) grid_model[r][c] = v;
      end
      KIND_READ: begin
        if (r < GRID_H && c < GRID_W) res = grid_model[r][c];
      end
      KIND_ADVANCE: begin
        next_generation();
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  // Hold start high until the transfer, then record the expected cell.
  task automatic send_cmd(input logic [KIND_W-1:0] k, input logic [ROW_W-1:0] r,
                          input logic [COL_W-1:0] c, input logic v,
                          input logic known = 1'b0, input logic known_val = 1'b0);
    logic predicted;
    if (items_sent >= CALM_FROM) idle_on = 1'b0;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    start_i   <= 1'b1;
    kind_i    <= k;
    row_i     <= r;
    col_i     <= c;
    cell_in_i <= v;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    predicted = apply_command(k, r, c, v);
    cell_q.push_back(known ? known_val : predicted);
    items_sent++;
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    while (cell_q.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (cell_q.size() == 0) begin
        report_mismatch("result with nothing outstanding");
      end else begin
        want_cell = cell_q.pop_front();
        if (cell_out_o !== want_cell)
          report_mismatch($sformatf("cell_out %b, want %b", cell_out_o, want_cell));
      end
    end
  end

  // Abort when no transfer happens on either side for too long.
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (start_i && !busy_o) || done_o) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("[life_automaton_grid_step] ERROR");
    $finish;
  end

  initial begin
    int pick;
    int h;
    int w;
    int b0;
    int c0;
    int nadv;
    int rr;
    int cc;
    bit drained_once;
    drained_once = 1'b0;
    rst_ni    <= 1'b0;
    start_i   <= 1'b0;
    kind_i    <= KIND_WRITE;
    row_i     <= '0;
    col_i     <= '0;
    cell_in_i <= 1'b0;
    foreach (grid_model[i]) grid_model[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i])
      send_cmd(dir_tbl[i].kind, dir_tbl[i].row, dir_tbl[i].col, dir_tbl[i].cell_val,
               dir_tbl[i].known, dir_tbl[i].known_val);

    while (items_sent < NUM_DIRECTED + NUM_ITEMS) begin
      pick = $urandom_range(0, 9);
      idle_on = ($urandom_range(0, 2) != 0);
      if (!drained_once && items_sent >= 250) begin
        drain_results();
        drained_once = 1'b1;
      end
      if (pick < 6) begin
        // seed a small patch, evolve it, and probe around it
        h = $urandom_range(3, 5);
        w = $urandom_range(3, 5);
        b0 = $urandom_range(0, GRID_H - h);
        c0 = $urandom_range(0, GRID_W - w);
        for (int i = 0; i < h; i++)
          for (int j = 0; j < w; j++)
            send_cmd(KIND_WRITE, ROW_W'(b0 + i), COL_W'(c0 + j), 1'($urandom_range(0, 1)));
        nadv = $urandom_range(0, 3);
        for (int g = 0; g <= nadv; g++) begin
          if (g > 0)
            send_cmd(KIND_ADVANCE, ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 31)),
                     1'($urandom_range(0, 1)));
          repeat (5) begin
            rr = b0 - 1 + $urandom_range(0, h + 1);
            cc = c0 - 1 + $urandom_range(0, w + 1);
            if (rr < 0) rr = 0;
            if (rr > GRID_H - 1) rr = GRID_H - 1;
            if (cc < 0) cc = 0;
            if (cc > GRID_W - 1) cc = GRID_W - 1;
            send_cmd(KIND_READ, ROW_W'(rr), COL_W'(cc), 1'($urandom_range(0, 1)));
          end
        end
      end else if (pick < 9) begin
        repeat (5)
          send_cmd(KIND_W'($urandom_range(0, 3)), ROW_W'($urandom_range(0, 31)),
                   COL_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
      end else begin
        drain_results();
      end
    end

    drain_results();
    repeat (GRID_H + 8) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("[life_automaton_grid_step] OK");
    else
      $display("[life_automaton_grid_step] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
